@@ sv/bld_pkg.sv @@
// Package: shared codes and defaults for the bounded linear deque.
package bld_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W = 5;
  localparam int DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_REAR  = 2'd1,
    ACT_RM_FRONT  = 2'd2,
    ACT_RM_REAR   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_FRONT = 3'd2,
    ST_NO_REAR  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // Decision made by the pointer unit for the item at the input.
  typedef struct packed {
    status_t status;
    logic    wr_en;
    logic    rd_en;
    logic    now_empty;
  } decision_t;

endpackage

@@ sv/bld_store.sv @@
// Data store: single-port synchronous memory with a registered read.
module bld_store #(
  parameter int DEPTH = bld_pkg::DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [AW-1:0]               addr,
  input  logic [bld_pkg::DATA_W-1:0]  wdata,
  output logic [bld_pkg::DATA_W-1:0]  rdata
);

  logic [bld_pkg::DATA_W-1:0] mem [DEPTH];
  logic [bld_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bld_ptr.sv @@
// Pointer unit: front/rear positions, empty flag and the per-item decision.
module bld_ptr #(
  parameter int DEPTH = bld_pkg::DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  bld_pkg::action_t           action,
  input  logic [bld_pkg::CAP_W-1:0]  capacity,
  output bld_pkg::decision_t         dec,
  output logic [AW-1:0]              addr
);

  localparam int CW = ((AW > bld_pkg::CAP_W) ? AW : bld_pkg::CAP_W) + 1;

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r, rear_nxt;
  logic          empty_r, empty_nxt;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_eff;
  logic          at_top;
  logic          front_side;
  logic          front_zero;

  // Clamp capacity into 1..DEPTH.
  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign at_top     = !empty_r && (CW'(rear_r) >= (cap_eff - CW'(1)));
  assign front_side = (action == bld_pkg::ACT_INS_FRONT) || (action == bld_pkg::ACT_RM_FRONT);
  assign front_zero = (front_r == '0);

  always_comb begin
    dec.status    = bld_pkg::ST_OK;
    dec.wr_en     = 1'b0;
    dec.rd_en     = 1'b0;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    empty_nxt     = empty_r;
    addr          = front_r;
    case (action)
      bld_pkg::ACT_INS_FRONT, bld_pkg::ACT_INS_REAR: begin
        if (!empty_r && front_zero && at_top) begin
          dec.status = bld_pkg::ST_FULL;
        end else if (front_side && !empty_r && front_zero) begin
          dec.status = bld_pkg::ST_NO_FRONT;
        end else if (!front_side && at_top) begin
          dec.status = bld_pkg::ST_NO_REAR;
        end else if (empty_r) begin
          dec.wr_en = 1'b1;
          addr      = '0;
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
        end else if (front_side) begin
          dec.wr_en = 1'b1;
          front_nxt = front_r - AW'(1);
          addr      = front_r - AW'(1);
        end else begin
          dec.wr_en = 1'b1;
          rear_nxt  = rear_r + AW'(1);
          addr      = rear_r + AW'(1);
        end
      end
      bld_pkg::ACT_RM_FRONT, bld_pkg::ACT_RM_REAR: begin
        if (empty_r) begin
          dec.status = bld_pkg::ST_EMPTY;
        end else begin
          dec.rd_en = 1'b1;
          addr      = front_side ? front_r : rear_r;
          if (front_r == rear_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (front_side) begin
            front_nxt = front_r + AW'(1);
          end else begin
            rear_nxt = rear_r - AW'(1);
          end
        end
      end
      default: begin
        dec.status = bld_pkg::ST_OK;
      end
    endcase
    dec.now_empty = empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
    end else if (go) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

@@ sv/bounded_linear_deque.sv @@
// Top level: bounded linear deque with store memory, pointer unit and result register.
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   in      | in_valid, in_ready, in_action, in_value            | input
//   out     | out_valid, out_ready, out_status,                  | output
//           |   out_removed_value, out_now_empty                 |
//   cfg     | cfg_we, cfg_wdata (capacity)                       | input
//
// For inserts, refused actions and removals from an empty deque, the result is in
// the output register the cycle after the transfer. A successful removal waits for
// the registered read of the store memory before its result is valid; no new item
// is taken while that read is outstanding. A new item is taken while a result
// waits, provided the result is taken in the same cycle. Reset (rst_n low,
// synchronous) empties the deque and sets capacity to 16; the store itself is not
// cleared.
module bounded_linear_deque #(
  parameter int DEPTH = bld_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic signed [bld_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic signed [bld_pkg::DATA_W-1:0] out_removed_value,
  output logic                              out_now_empty,
  input  logic                              cfg_we,
  input  logic [bld_pkg::CAP_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                       state_r, state_nxt;
  logic [bld_pkg::CAP_W-1:0]    cap_r;
  logic                         out_valid_r, out_valid_nxt;
  bld_pkg::status_t             out_status_r;
  logic [bld_pkg::DATA_W-1:0]   out_value_r;
  logic                         out_empty_r;
  logic                         go;
  bld_pkg::decision_t           dec;
  logic [AW-1:0]                addr;
  logic [bld_pkg::DATA_W-1:0]   rdata;

  // Take a new item only when no read is pending and the result slot frees up.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign go       = in_valid && in_ready;

  // Capacity register: written whenever enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bld_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  bld_ptr #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .action   (bld_pkg::action_t'(in_action)),
    .capacity (cap_r),
    .dec      (dec),
    .addr     (addr)
  );

  // Writes and reads land on the accept edge; a removal's data appears next cycle.
  bld_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (go && dec.wr_en),
    .re    (go && dec.rd_en),
    .addr  (addr),
    .wdata (in_value),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          // Removal with data: hold the result back until the read returns.
          out_valid_nxt = !dec.rd_en;
          state_nxt     = dec.rd_en ? S_READ : S_IDLE;
        end else if (out_ready) begin
          out_valid_nxt = 1'b0;
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: status and empty flag on transfer, data when the read returns.
  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= dec.status;
      out_empty_r  <= dec.now_empty;
      out_value_r  <= '0;
    end else if (state_r == S_READ) begin
      out_value_r <= rdata;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_value_r;
  assign out_now_empty     = out_empty_r;

endmodule

@@ sv/bld_checker.sv @@
// Checker: port-level assertions for the bounded linear deque, bound to the top.
module bld_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [2:0]                        out_status,
  input logic signed [bld_pkg::DATA_W-1:0] out_removed_value,
  input logic                              out_now_empty
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_removed_value) && $stable(out_now_empty))
    else $error("result changed while stalled");

  // Only a successful removal carries data.
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bld_pkg::ST_OK |-> out_removed_value == '0)
    else $error("refused action returned data");

  // Removal from an empty deque leaves it empty.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bld_pkg::ST_EMPTY |-> out_now_empty)
    else $error("empty status with non-empty flag");

  // Refused inserts only happen on a deque that holds elements.
  a_refused_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bld_pkg::ST_FULL || out_status == bld_pkg::ST_NO_FRONT
      || out_status == bld_pkg::ST_NO_REAR) |-> !out_now_empty)
    else $error("refused insert on empty deque");

endmodule

bind bounded_linear_deque bld_checker u_bld_checker (.*);
